// ----- sv/apu_pkg.sv -----
`default_nettype none
package apu_pkg;

  localparam int unsigned PARAM_COUNT_DEF = 4096;
  localparam int IDX_W  = 12;
  localparam int DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA_FIRST   = 3'd0,
    REG_BETA_SECOND  = 3'd1,
    REG_EPSILON      = 3'd2,
    REG_STEP_RATE    = 3'd3,
    REG_FIRST_CORR   = 3'd4,
    REG_SECOND_CORR  = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] BETA_FIRST_RST  = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST = 16'd65470;
  localparam logic [15:0] EPSILON_RST     = 16'd1;
  localparam logic [31:0] STEP_RATE_RST   = 32'd16777;
  localparam logic [31:0] FIRST_CORR_RST  = 32'd655360;
  localparam logic [31:0] SECOND_CORR_RST = 32'd65536000;

  typedef struct packed {
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [15:0] epsilon_term;
    logic [31:0] step_rate;
    logic [31:0] first_correction;
    logic [31:0] second_correction;
  } cfg_t;

  // per-item info that rides along the arithmetic pipeline
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     neg;
    logic                     sat;
  } side_t;

endpackage
`default_nettype wire

// ----- sv/apu_ram.sv -----
`default_nettype none
module apu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- sv/apu_moment.sv -----
`default_nettype none
module apu_moment #(
  parameter int unsigned PARAM_COUNT = apu_pkg::PARAM_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire apu_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  input  wire logic [apu_pkg::IDX_W-1:0]      in_idx,
  input  wire logic signed [31:0]             in_grad,
  input  wire logic signed [31:0]             in_value,
  input  wire logic                           in_last,
  output logic                                busy,
  output logic                                out_valid,
  output logic signed [31:0]                  out_m,
  output logic [31:0]                         out_v,
  output apu_pkg::side_t                      out_side
);
  import apu_pkg::*;

  localparam int ADDR_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int CNT_W  = $clog2(PARAM_COUNT + 1);

  // clearing sweep after reset
  logic [CNT_W-1:0] clr_cnt;
  assign busy = (32'(clr_cnt) < PARAM_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // gradient square ahead of the read
  logic [31:0] ga;
  logic [63:0] gg;
  assign ga = in_grad[31] ? 32'(-in_grad) : 32'(in_grad);
  assign gg = 64'(ga) * 64'(ga);

  logic               v1;
  logic [IDX_W-1:0]   idx1;
  logic signed [31:0] grad1;
  logic signed [31:0] value1;
  logic               last1;
  logic               in1;
  logic [31:0]        gsq1;
  logic               gsat1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1   <= in_idx;
      grad1  <= in_grad;
      value1 <= in_value;
      last1  <= in_last;
      in1    <= (32'(in_idx) < PARAM_COUNT);
      gsq1   <= (|gg[63:48]) ? 32'hFFFF_FFFF : gg[47:16];
      gsat1  <= |gg[63:48];
    end
  end

  logic [63:0] rdata;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [63:0] ram_wdata;

  // forward of the most recent write: covers the read that raced it
  logic               fwd_valid;
  logic [IDX_W-1:0]   fwd_idx;
  logic signed [31:0] fwd_m;
  logic [31:0]        fwd_v;

  logic signed [31:0] m_old;
  logic [31:0]        v_old;
  logic signed [31:0] m_new;
  logic [31:0]        v_new;

  always_comb begin
    logic               hit;
    logic signed [17:0] sb1;
    logic signed [17:0] sc1;
    logic [16:0]        omb2;
    logic signed [50:0] mt;
    logic signed [50:0] mr;
    logic [49:0]        vt;
    logic [33:0]        vs;
    hit = fwd_valid && (fwd_idx == idx1);
    if (!in1) begin
      m_old = '0;
      v_old = '0;
    end else if (hit) begin
      m_old = fwd_m;
      v_old = fwd_v;
    end else begin
      m_old = $signed(rdata[31:0]);
      v_old = rdata[63:32];
    end
    sb1  = $signed({2'b00, cfg.beta_first});
    sc1  = $signed({1'b0, 17'h10000 - {1'b0, cfg.beta_first}});
    omb2 = 17'h10000 - {1'b0, cfg.beta_second};
    mt = (51'(sb1) * 51'(m_old)) + (51'(sc1) * 51'(grad1));
    mr = (mt + 51'sd32768) >>> 16;
    if (mr > 51'sd2147483647) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (mr < -51'sd2147483648) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = mr[31:0];
    end
    vt = (50'(cfg.beta_second) * 50'(v_old)) + (50'(omb2) * 50'(gsq1)) + 50'd32768;
    vs = vt[49:16];
    v_new = (|vs[33:32]) ? 32'hFFFF_FFFF : vs[31:0];
  end

  assign ram_we    = busy || (en && v1 && in1);
  assign ram_waddr = busy ? clr_cnt[ADDR_W-1:0] : ADDR_W'(idx1);
  assign ram_wdata = busy ? 64'd0 : {v_new, m_new};

  apu_ram #(
    .WIDTH (64),
    .DEPTH (PARAM_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (ADDR_W'(in_idx)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (en && v1 && in1 && !busy) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1 && in1 && !busy) begin
      fwd_idx <= idx1;
      fwd_m   <= m_new;
      fwd_v   <= v_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_m          <= m_new;
      out_v          <= v_new;
      out_side.idx   <= idx1;
      out_side.value <= value1;
      out_side.last  <= last1;
      out_side.neg   <= 1'b0;
      out_side.sat   <= gsat1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/apu_sqrt.sv -----
`default_nettype none
module apu_sqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [63:0]       radicand,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            root,
  output logic [SIDE_W-1:0]      out_side
);
  localparam int N = 32;

  // one result bit per stage
  logic              vld  [0:N];
  logic [63:0]       rad  [0:N];
  logic [34:0]       rem  [0:N];
  logic [31:0]       res  [0:N];
  logic [SIDE_W-1:0] side [0:N];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign res[0]  = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [34:0] rs;
    logic [34:0] tr;
    logic        ge;
    assign rs = {rem[i][32:0], rad[i][63:62]};
    assign tr = {1'b0, res[i], 2'b01};
    assign ge = (rs >= tr);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= {rad[i][61:0], 2'b00};
        rem[i+1]  <= ge ? (rs - tr) : rs;
        res[i+1]  <= {res[i][30:0], ge};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
  assign out_side  = side[N];
endmodule
`default_nettype wire

// ----- sv/apu_div.sv -----
`default_nettype none
module apu_div #(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [63:0]       num,
  input  wire logic [32:0]       den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            quot,
  output logic                   sat,
  output logic [SIDE_W-1:0]      out_side
);
  localparam int N = 32;

  logic              vld  [0:N];
  logic [32:0]       rem  [0:N];
  logic [31:0]       lo   [0:N];
  logic [32:0]       dv   [0:N];
  logic [31:0]       q    [0:N];
  logic              sf   [0:N];
  logic [SIDE_W-1:0] side [0:N];

  // entry stage: overflow check, quotient >= 2^32 when high word >= divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {1'b0, num[63:32]};
      lo[0]   <= num[31:0];
      dv[0]   <= den;
      q[0]    <= '0;
      sf[0]   <= ({1'b0, num[63:32]} >= den);
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0] rs;
    logic        ge;
    assign rs = {rem[i], lo[i][31]};
    assign ge = (rs >= {1'b0, dv[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? 33'(rs - {1'b0, dv[i]}) : rs[32:0];
        lo[i+1]   <= {lo[i][30:0], 1'b0};
        dv[i+1]   <= dv[i];
        q[i+1]    <= {q[i][30:0], ge};
        sf[i+1]   <= sf[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign quot      = sf[N] ? 32'hFFFF_FFFF : q[N];
  assign sat       = sf[N];
  assign out_side  = side[N];
endmodule
`default_nettype wire

// ----- sv/adam_parameter_update.sv -----
// Adam optimizer update, one trainable parameter per beat, Q16.16.
// Input stream (s_axis): one beat per parameter carrying its flat index,
// gradient and current value; tlast marks the last parameter of a pass.
// Output stream (m_axis): one beat per input beat, in order, with the index,
// the updated value, a saturation flag on tuser and the copied tlast.
// Config port: cfg_we/cfg_index/cfg_data write the decay, guard, rate and
// bias-correction registers; write them only while the stream is idle.
// Throughput: one beat per cycle, sustained. The pipeline is fully stalled
// only when its last stage holds a result and the output register is full
// and not taken; bubbles keep draining while a result waits.
// Stages from input accept to the output register: moment read/update, a
// multiply, the 32-stage square root (one root bit per stage), the 33-stage
// divider (overflow check, then one quotient bit per stage), a multiply.
// Moments live in one RAM (64 bits x PARAM_COUNT); same-index beats back to
// back are resolved by forwarding the last written entry.
// Reset: synchronous, active high. Registers return to defaults and a
// clearing sweep zeroes the moment RAM, one entry per cycle, over all
// PARAM_COUNT entries (4096 by default); s_axis_tready stays low until it finishes.
// Indexes at or above PARAM_COUNT compute with zero moments and write nothing.
`default_nettype none
module adam_parameter_update #(
  parameter int unsigned PARAM_COUNT = apu_pkg::PARAM_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [11:0] param_index, [43:12] gradient, [75:44] param_value, [79:76] zero
  input  wire logic [79:0]                       s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [11:0] out_index, [43:12] new_value, [47:44] zero
  output logic [47:0]                            m_axis_tdata,
  // [0] saturated
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [apu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [apu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import apu_pkg::*;

  localparam int SIDE_W    = $bits(side_t);
  localparam int SQ_SIDE_W = 64 + SIDE_W;

  // ---------------- configuration registers ----------------
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beta_first        <= BETA_FIRST_RST;
      cfg.beta_second       <= BETA_SECOND_RST;
      cfg.epsilon_term      <= EPSILON_RST;
      cfg.step_rate         <= STEP_RATE_RST;
      cfg.first_correction  <= FIRST_CORR_RST;
      cfg.second_correction <= SECOND_CORR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BETA_FIRST:  cfg.beta_first        <= cfg_data[15:0];
        REG_BETA_SECOND: cfg.beta_second       <= cfg_data[15:0];
        REG_EPSILON:     cfg.epsilon_term      <= cfg_data[15:0];
        REG_STEP_RATE:   cfg.step_rate         <= cfg_data;
        REG_FIRST_CORR:  cfg.first_correction  <= cfg_data;
        REG_SECOND_CORR: cfg.second_correction <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  // Whole pipeline moves unless the last stage is stuck behind a full,
  // untaken output register.
  logic en;
  logic busy;
  logic vp;
  logic o_valid;

  assign en            = !vp || !o_valid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  // ---------------- moments: read, update, write back ----------------
  logic               mo_valid;
  logic signed [31:0] mo_m;
  logic [31:0]        mo_v;
  side_t              mo_side;

  apu_moment #(
    .PARAM_COUNT (PARAM_COUNT)
  ) u_moment (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid && s_axis_tready),
    .in_idx    (s_axis_tdata[11:0]),
    .in_grad   ($signed(s_axis_tdata[43:12])),
    .in_value  ($signed(s_axis_tdata[75:44])),
    .in_last   (s_axis_tlast),
    .busy      (busy),
    .out_valid (mo_valid),
    .out_m     (mo_m),
    .out_v     (mo_v),
    .out_side  (mo_side)
  );

  // ---------------- bias correction products ----------------
  logic        v3;
  logic [63:0] vc3;     // v * C2, Q32.32
  logic [63:0] num3;    // |m| * C1
  side_t       side3;
  logic [31:0] ma;

  assign ma = mo_m[31] ? 32'(-mo_m) : 32'(mo_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= mo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc3         <= 64'(mo_v) * 64'(cfg.second_correction);
      num3        <= 64'(ma) * 64'(cfg.first_correction);
      side3.idx   <= mo_side.idx;
      side3.value <= mo_side.value;
      side3.last  <= mo_side.last;
      side3.neg   <= mo_m[31];
      side3.sat   <= mo_side.sat;
    end
  end

  // ---------------- square root ----------------
  logic                 sq_valid;
  logic [31:0]          sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic [63:0]          sq_num;
  side_t                sq_info;
  logic [32:0]          den;

  apu_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .radicand  (vc3),
    .in_side   ({num3, side3}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign sq_num  = sq_side[SQ_SIDE_W-1:SIDE_W];
  assign sq_info = sq_side[SIDE_W-1:0];

  // zero denominator taken as one LSB
  always_comb begin
    logic [32:0] d;
    d   = {1'b0, sq_root} + 33'(cfg.epsilon_term);
    den = (d == 33'd0) ? 33'd1 : d;
  end

  // ---------------- divide ----------------
  logic        dv_valid;
  logic [31:0] dv_q;
  logic        dv_sat;
  side_t       dv_side;

  apu_div #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (sq_num),
    .den       (den),
    .in_side   (sq_info),
    .out_valid (dv_valid),
    .quot      (dv_q),
    .sat       (dv_sat),
    .out_side  (dv_side)
  );

  // ---------------- rate product ----------------
  logic [63:0] prod_p;
  side_t       side_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_p       <= 64'(dv_q) * 64'(cfg.step_rate);
      side_p.idx   <= dv_side.idx;
      side_p.value <= dv_side.value;
      side_p.last  <= dv_side.last;
      side_p.neg   <= dv_side.neg;
      side_p.sat   <= dv_side.sat | dv_sat;
    end
  end

  // ---------------- final add and output register ----------------
  logic [IDX_W-1:0]   o_idx;
  logic signed [31:0] o_value;
  logic               o_sat;
  logic               o_last;
  logic signed [31:0] nv_sat;
  logic               nv_flag;

  always_comb begin
    logic [64:0]        rsum;
    logic [40:0]        step;
    logic signed [42:0] nv;
    rsum = {1'b0, prod_p} + 65'h80_0000;
    step = rsum[64:24];
    if (side_p.neg) begin
      nv = 43'(side_p.value) + $signed({2'b00, step});
    end else begin
      nv = 43'(side_p.value) - $signed({2'b00, step});
    end
    if (nv > 43'sd2147483647) begin
      nv_sat  = 32'sh7FFF_FFFF;
      nv_flag = 1'b1;
    end else if (nv < -43'sd2147483648) begin
      nv_sat  = 32'sh8000_0000;
      nv_flag = 1'b1;
    end else begin
      nv_sat  = nv[31:0];
      nv_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || m_axis_tready) begin
      o_valid <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || m_axis_tready) begin
      o_idx   <= side_p.idx;
      o_value <= nv_sat;
      o_sat   <= side_p.sat | nv_flag;
      o_last  <= side_p.last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {4'b0000, o_value, o_idx};
  assign m_axis_tuser  = o_sat;
  assign m_axis_tlast  = o_last;

`ifndef SYNTHESIS
  // no beat taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("input accepted while moment RAM is clearing");

  // divider never sees a zero divisor
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> (den != 33'd0))
    else $error("zero divisor entered divider");

  // a stuck last stage keeps its item until the output frees up
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (vp && o_valid && !m_axis_tready) |=> (vp && o_valid))
    else $error("pipeline item lost under output stall");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_adam_parameter_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Adam update scoreboard: tracks the moment memories and the registers,
// predicts each updated value and checks beats in order.
class adam_scoreboard;
  logic [31:0] mom1 [0:4095];
  logic [31:0] mom2 [0:4095];
  logic [15:0] beta1, beta2, eps;
  logic [31:0] rate, corr1, corr2;
  logic [47:0] exp_data [$];
  logic        exp_sat [$];
  logic        exp_last [$];
  int          mismatches;
  int          checked;

  function new();
    beta1 = apu_pkg::BETA_FIRST_RST;
    beta2 = apu_pkg::BETA_SECOND_RST;
    eps   = apu_pkg::EPSILON_RST;
    rate  = apu_pkg::STEP_RATE_RST;
    corr1 = apu_pkg::FIRST_CORR_RST;
    corr2 = apu_pkg::SECOND_CORR_RST;
    for (int i = 0; i < 4096; i++) begin
      mom1[i] = '0;
      mom2[i] = '0;
    end
    mismatches = 0;
    checked = 0;
  endfunction

  function void set_reg(apu_pkg::cfg_reg_t r, logic [31:0] d);
    case (r)
      apu_pkg::REG_BETA_FIRST:  beta1 = d[15:0];
      apu_pkg::REG_BETA_SECOND: beta2 = d[15:0];
      apu_pkg::REG_EPSILON:     eps = d[15:0];
      apu_pkg::REG_STEP_RATE:   rate = d;
      apu_pkg::REG_FIRST_CORR:  corr1 = d;
      apu_pkg::REG_SECOND_CORR: corr2 = d;
      default: ;
    endcase
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // note one accepted parameter beat and queue its updated value
  function void note_param(logic [11:0] idx, logic signed [31:0] g,
                           logic signed [31:0] val, logic last);
    longint m, t, nv;
    logic [63:0] ga, gsq, v, root, d, ma, q, stp;
    logic sat;
    sat = 1'b0;
    m = $signed(mom1[idx]);
    v = {32'd0, mom2[idx]};
    // arithmetic shift of t+2^15 equals floor division
    t = longint'(beta1) * m + (65536 - longint'(beta1)) * longint'(g) + 32768;
    m = t >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    ga = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
    gsq = (ga * ga) >> 16;
    if (gsq > 64'hFFFFFFFF) begin
      gsq = 64'hFFFFFFFF;
      sat = 1'b1;
    end
    v = (64'(beta2) * v + (64'd65536 - 64'(beta2)) * gsq + 64'd32768) >> 16;
    if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
    mom1[idx] = m[31:0];
    mom2[idx] = v[31:0];
    root = int_sqrt(v * 64'(corr2));
    d = root + 64'(eps);
    if (d == 0) d = 1;   // zero denominator taken as one LSB
    ma = (m < 0) ? 64'(-m) : 64'(m);
    q = (ma * 64'(corr1)) / d;
    if (q > 64'hFFFFFFFF) begin
      q = 64'hFFFFFFFF;
      sat = 1'b1;
    end
    stp = (q * 64'(rate) + (64'd1 << 23)) >> 24;
    nv = (m < 0) ? longint'(val) + longint'(stp) : longint'(val) - longint'(stp);
    if (nv > 64'sd2147483647) begin
      nv = 64'sd2147483647;
      sat = 1'b1;
    end
    if (nv < -64'sd2147483648) begin
      nv = -64'sd2147483648;
      sat = 1'b1;
    end
    exp_data.push_back({4'd0, nv[31:0], idx});
    exp_sat.push_back(sat);
    exp_last.push_back(last);
  endfunction

  function void check_result(logic [47:0] data, logic sat, logic last);
    logic [47:0] ed;
    logic es, el;
    checked++;
    if (exp_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: data=%h sat=%b last=%b", data, sat, last);
      return;
    end
    ed = exp_data.pop_front();
    es = exp_sat.pop_front();
    el = exp_last.pop_front();
    if (data !== ed || sat !== es || last !== el) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: idx exp %0d got %0d, value exp %h got %h, ",
                  "sat exp %b got %b, last exp %b got %b"},
                 ed[11:0], data[11:0], ed[43:12], data[43:12], es, sat, el, last);
    end
  endfunction

  function int pending();
    return exp_data.size();
  endfunction
endclass

module tb_adam_parameter_update;
  import apu_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [11:0] param_index, [43:12] gradient, [75:44] param_value, [79:76] zero
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [11:0] out_index, [43:12] new_value, [47:44] zero
  logic [47:0] m_axis_tdata;
  // [0] saturated
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adam_parameter_update DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  adam_scoreboard moments = new();
  int  params_sent = 0;
  int  sink_holdoff = 0;   // cycles of forced back-pressure requested

  // short gaps mostly, sometimes long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // check every result beat taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        moments.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver: random stalls plus requested long hold-offs
  initial begin : sink_proc
    int stall;
    @(posedge clk);
    while (1) begin
      if (sink_holdoff > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_holdoff) @(posedge clk);
        sink_holdoff = 0;
      end
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    moments.set_reg(r, d);
  endtask

  // write to an index with no register: must be ignored
  task automatic write_unknown(logic [CFG_IDX_W-1:0] i, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_param(logic [11:0] idx, logic [31:0] g, logic [31:0] val,
                            logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, val, g, idx};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    moments.note_param(idx, g, val, last);
    params_sent++;
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every queued result has come back, then let the pipe drain
  task automatic drain();
    while (moments.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // random gradient: mostly moderate, sometimes extreme
  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'h80000);
    endcase
  endfunction

  task automatic random_pass(int count, int span);
    int base;
    base = $urandom_range(0, 4095);
    for (int i = 0; i < count; i++) begin
      logic [11:0] idx;
      // small span revisits entries so the moments build up
      idx = ($urandom_range(0, 9) == 0) ? 12'($urandom()) :
            12'(base + $urandom_range(0, span - 1));
      send_param(idx, rand_grad(), $urandom(), i == count - 1);
    end
    end_burst();
  endtask

  initial begin : main_proc
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, saturation, same-index beats in succession
    send_param(12'd0, 32'd0, 32'd0, 1'b0);
    send_param(12'd4095, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_param(12'd4095, 32'h80000000, 32'h80000000, 1'b0);
    send_param(12'd1, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_param(12'd1, 32'h00010000, 32'h80000000, 1'b0);
    send_param(12'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    send_param(12'd2, 32'h00000001, 32'h00000001, 1'b0);
    send_param(12'hAAA, 32'h55555555, 32'hAAAAAAAA, 1'b0);
    send_param(12'h555, 32'hAAAAAAAA, 32'h55555555, 1'b1);
    end_burst();
    drain();

    // zero denominator: eps 0 and a zero moment; also unknown registers
    write_reg(REG_EPSILON, 32'd0);
    write_unknown(3'd6, 32'hFFFFFFFF);
    write_unknown(3'd7, 32'h12345678);
    send_param(12'd100, 32'd0, 32'h00010000, 1'b0);
    send_param(12'd101, 32'h00000100, 32'd5, 1'b1);
    end_burst();
    drain();

    // extreme settings: huge rate and corrections force saturation
    write_reg(REG_BETA_FIRST, 32'd0);
    write_reg(REG_BETA_SECOND, 32'd65535);
    write_reg(REG_EPSILON, 32'd65535);
    write_reg(REG_STEP_RATE, 32'hFFFFFFFF);
    write_reg(REG_FIRST_CORR, 32'hFFFFFFFF);
    write_reg(REG_SECOND_CORR, 32'd65536);
    send_param(12'd200, 32'h7FFFFFFF, 32'h00000000, 1'b0);
    send_param(12'd201, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_param(12'd202, 32'h00000001, 32'h80000000, 1'b1);
    end_burst();
    drain();

    write_reg(REG_BETA_FIRST, 32'd65535);
    write_reg(REG_BETA_SECOND, 32'd0);
    write_reg(REG_STEP_RATE, 32'd0);
    write_reg(REG_FIRST_CORR, 32'd65536);
    write_reg(REG_SECOND_CORR, 32'hFFFFFFFF);
    random_pass(12, 4);
    drain();

    // back to typical values, then random passes with varied settings
    write_reg(REG_BETA_FIRST, BETA_FIRST_RST);
    write_reg(REG_BETA_SECOND, BETA_SECOND_RST);
    write_reg(REG_EPSILON, EPSILON_RST);
    write_reg(REG_STEP_RATE, STEP_RATE_RST);
    write_reg(REG_FIRST_CORR, FIRST_CORR_RST);
    write_reg(REG_SECOND_CORR, SECOND_CORR_RST);

    // back-pressure: receiver holds off while the sender keeps going
    sink_holdoff = 300;
    random_pass(200, 16);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_BETA_FIRST, $urandom_range(0, 65535));
      write_reg(REG_BETA_SECOND, $urandom_range(0, 65535));
      write_reg(REG_EPSILON, $urandom_range(0, 65535));
      write_reg(REG_STEP_RATE, $urandom_range(0, 3) == 0 ? $urandom() :
                               $urandom_range(0, 1 << 24));
      write_reg(REG_FIRST_CORR, $urandom_range(65536, 65536 * 20));
      write_reg(REG_SECOND_CORR, $urandom_range(0, 3) == 0 ?
                                 $urandom_range(65536, 32'hFFFFFFFF) :
                                 $urandom_range(65536, 65536 * 2000));
      random_pass(130, (p % 2) ? 8 : 64);
      drain();
    end

    $display("Covered %0d parameter beats over several register settings,", params_sent);
    $display("including saturation, zero denominator and a long output stall.");
    if (moments.mismatches == 0 && moments.pending() == 0)
      $display("[adam_parameter_update] OK");
    else
      $display("[adam_parameter_update] ERROR");
    $finish;
  end

  // reset sweep plus ~1300 beats with stalls fit well within this
  initial begin : watchdog
    #5ms;
    $display("[adam_parameter_update] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// ----- adam_parameter_update.f -----
sv/apu_pkg.sv
sv/apu_ram.sv
sv/apu_moment.sv
sv/apu_sqrt.sv
sv/apu_div.sv
sv/adam_parameter_update.sv
tb/tb_adam_parameter_update.sv
